// File: sv/scdp_pkg.sv
`timescale 1ns / 1ps

package scdp_pkg;

    // Descriptor type codes
    localparam logic [7:0] DESC_KIND_IFACE = 8'h04;
    localparam logic [7:0] DESC_KIND_ENDP  = 8'h05;

    // Minimum descriptor lengths for the fields we read
    localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
    localparam logic [7:0] ENDP_MIN_LEN  = 8'd7;
    localparam logic [7:0] DESC_MIN_LEN  = 8'd2;

    // Byte of the set that carries bConfigurationValue
    localparam logic [15:0] CFG_VALUE_POS = 16'd5;
    // Sets shorter than this give an all-zero result
    localparam logic [15:0] MIN_SET_BYTES = 16'd9;

    // Endpoint attribute transfer type
    localparam logic [7:0] ATTR_TYPE_MASK = 8'h03;
    localparam logic [7:0] ATTR_BULK      = 8'h02;
    localparam int         EP_DIR_BIT     = 7;

    // Field window covers descriptor bytes 2..7
    localparam int          WIN_DEPTH = 6;
    localparam logic [7:0]  WIN_FIRST = 8'd2;
    localparam logic [7:0]  WIN_END   = 8'd8;

    // Result queue depth: one slot draining, one being filled, one for the
    // last byte in the input register, so back-to-back sets never stall while m_axis is ready
    localparam int OUT_DEPTH = 3;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // Match register reset values
    localparam logic [7:0] MATCH_CLASS_RST    = 8'h08;
    localparam logic [7:0] MATCH_SUBCLASS_RST = 8'h06;
    localparam logic [7:0] MATCH_PROTOCOL_RST = 8'h50;

    typedef enum logic [1:0] {
        REG_MATCH_CLASS    = 2'd0,
        REG_MATCH_SUBCLASS = 2'd1,
        REG_MATCH_PROTOCOL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] iface_class;
        logic [7:0] iface_subclass;
        logic [7:0] iface_protocol;
    } match_cfg_t;

    typedef struct packed {
        logic        valid_res;
        logic [7:0]  conf_value;
        logic [7:0]  bulk_in_address;
        logic [15:0] in_max_pkt;
        logic [7:0]  bulk_out_address;
        logic [15:0] out_max_pkt;
    } result_t;

endpackage

// File: sv/storage_config_descriptor_parser.sv
`timescale 1ns / 1ps
// Pipeline: an accepted byte is held in the input register and parsed from
// there; the result of a last byte is written into the result queue, from
// which it is offered on m_axis.
// Throughput: one byte per cycle; the input stalls only while the receiver
// holds off and the three-entry result queue plus a last byte in flight fill.
// Reset (rst_n, async, active low): parse state cleared, match registers
// return to class 0x08, subclass 0x06, protocol 0x50.

module storage_config_descriptor_parser
    import scdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte

    // Result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] valid_res, [8:1] conf_value, [16:9] bulk_in_address,
    // [32:17] in_max_pkt, [40:33] bulk_out_address,
    // [56:41] out_max_pkt, [63:57] zero
    output logic [63:0] m_axis_tdata,

    // Match register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Match registers
    match_cfg_t match_reg;

    // Input register stage
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_last_reg;

    logic       in_accept;
    logic       res_valid;
    result_t    res;
    result_t    q_data;
    logic [OUT_AW:0] q_count;
    logic [OUT_AW+1:0] q_claimed;

    // Config writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg.iface_class    <= MATCH_CLASS_RST;
            match_reg.iface_subclass <= MATCH_SUBCLASS_RST;
            match_reg.iface_protocol <= MATCH_PROTOCOL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MATCH_CLASS:    match_reg.iface_class    <= cfg_data;
                REG_MATCH_SUBCLASS: match_reg.iface_subclass <= cfg_data;
                REG_MATCH_PROTOCOL: match_reg.iface_protocol <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Only a last byte makes a result, so only a last byte in the input
    // register holds a claim on a queue slot.
    assign q_claimed     = {1'b0, q_count} +
                           {{(OUT_AW+1){1'b0}}, stg_valid_reg && stg_last_reg};
    assign s_axis_tready = q_claimed < (OUT_AW+2)'(OUT_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stg_byte_reg <= s_axis_tdata;
            stg_last_reg <= s_axis_tlast;
        end
    end

    // Descriptor walk and result build
    scdp_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (stg_valid_reg),
        .item_byte  (stg_byte_reg),
        .item_last  (stg_last_reg),
        .match_cfg  (match_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result queue decouples output stalls from the byte stream
    scdp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (q_data),
        .count     (q_count)
    );

    assign m_axis_tdata = {7'd0,
                           q_data.out_max_pkt,
                           q_data.bulk_out_address,
                           q_data.in_max_pkt,
                           q_data.bulk_in_address,
                           q_data.conf_value,
                           q_data.valid_res};

endmodule

// File: sv/scdp_walker.sv
`timescale 1ns / 1ps

module scdp_walker
    import scdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       item_last,
    input  match_cfg_t match_cfg,
    output logic       res_valid,
    output result_t    res
);

    logic [15:0] pos_reg,     pos_next;
    logic [7:0]  off_reg,     off_next;
    logic [7:0]  len_reg,     len_next;
    logic [7:0]  kind_reg,    kind_next;
    logic [7:0]  win_reg  [WIN_DEPTH];
    logic [7:0]  win_next [WIN_DEPTH];
    logic        stop_reg,    stop_next;
    logic        iface_reg,   iface_next;
    logic [7:0]  cfgv_reg,    cfgv_next;
    logic [7:0]  in_addr_reg, in_addr_next;
    logic [15:0] in_mps_reg,  in_mps_next;
    logic [7:0]  out_addr_reg, out_addr_next;
    logic [15:0] out_mps_reg,  out_mps_next;

    logic [7:0]  len_eff;
    logic        desc_done;
    logic [15:0] ep_mps;
    logic        ok;

    always_comb
    begin
        pos_next      = pos_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        win_next      = win_reg;
        stop_next     = stop_reg;
        iface_next    = iface_reg;
        cfgv_next     = cfgv_reg;
        in_addr_next  = in_addr_reg;
        in_mps_next   = in_mps_reg;
        out_addr_next = out_addr_reg;
        out_mps_next  = out_mps_reg;
        len_eff       = (off_reg == 8'd0) ? item_byte : len_reg;
        desc_done     = 1'b0;
        ep_mps        = {win_reg[3], win_reg[2]};

        if (pos_reg == CFG_VALUE_POS)
        begin
            cfgv_next = item_byte;
        end

        if (!stop_reg)
        begin
            if (off_reg == 8'd0)
            begin
                len_next = item_byte;
            end
            else if (off_reg == 8'd1)
            begin
                kind_next = item_byte;
            end
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                if (off_reg == WIN_FIRST + 8'(i))
                begin
                    win_next[i] = item_byte;
                end
            end

            if (off_reg == 8'd0 && item_byte < DESC_MIN_LEN)
            begin
                stop_next = 1'b1;
            end
            else
            begin
                desc_done = ({1'b0, off_reg} + 9'd1) == {1'b0, len_eff};
                off_next  = desc_done ? 8'd0 : off_reg + 8'd1;
            end
        end

        // Window bytes 0..5 are settled before the final byte of a
        // descriptor long enough to use them.
        if (desc_done)
        begin
            if (kind_reg == DESC_KIND_IFACE && len_reg >= IFACE_MIN_LEN)
            begin
                iface_next = (win_reg[3] == match_cfg.iface_class) &&
                             (win_reg[4] == match_cfg.iface_subclass) &&
                             (win_reg[5] == match_cfg.iface_protocol);
            end
            else if (kind_reg == DESC_KIND_ENDP && iface_reg &&
                     len_reg >= ENDP_MIN_LEN &&
                     (win_reg[1] & ATTR_TYPE_MASK) == ATTR_BULK)
            begin
                if (win_reg[0][EP_DIR_BIT])
                begin
                    in_addr_next = win_reg[0];
                    in_mps_next  = ep_mps;
                end
                else
                begin
                    out_addr_next = win_reg[0];
                    out_mps_next  = ep_mps;
                end
            end
        end

        if (pos_reg != 16'hFFFF)
        begin
            pos_next = pos_reg + 16'd1;
        end
    end

    // Result from the updated values
    always_comb
    begin
        ok = (in_addr_next != 8'd0) && (out_addr_next != 8'd0) &&
             (in_mps_next != 16'd0) && (out_mps_next != 16'd0);
        res_valid = item_valid && item_last;
        if (pos_reg < (MIN_SET_BYTES - 16'd1))
        begin
            res = '0;
        end
        else
        begin
            res.valid_res        = ok;
            res.conf_value       = cfgv_next;
            res.bulk_in_address  = in_addr_next;
            res.in_max_pkt       = in_mps_next;
            res.bulk_out_address = out_addr_next;
            res.out_max_pkt      = out_mps_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            off_reg      <= '0;
            len_reg      <= '0;
            kind_reg     <= '0;
            win_reg      <= '{default: '0};
            stop_reg     <= 1'b0;
            iface_reg    <= 1'b0;
            cfgv_reg     <= '0;
            in_addr_reg  <= '0;
            in_mps_reg   <= '0;
            out_addr_reg <= '0;
            out_mps_reg  <= '0;
        end
        else if (item_valid)
        begin
            if (item_last)
            begin
                pos_reg      <= '0;
                off_reg      <= '0;
                len_reg      <= '0;
                kind_reg     <= '0;
                win_reg      <= '{default: '0};
                stop_reg     <= 1'b0;
                iface_reg    <= 1'b0;
                cfgv_reg     <= '0;
                in_addr_reg  <= '0;
                in_mps_reg   <= '0;
                out_addr_reg <= '0;
                out_mps_reg  <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                off_reg      <= off_next;
                len_reg      <= len_next;
                kind_reg     <= kind_next;
                win_reg      <= win_next;
                stop_reg     <= stop_next;
                iface_reg    <= iface_next;
                cfgv_reg     <= cfgv_next;
                in_addr_reg  <= in_addr_next;
                in_mps_reg   <= in_mps_next;
                out_addr_reg <= out_addr_next;
                out_mps_reg  <= out_mps_next;
            end
        end
    end

endmodule

// File: sv/scdp_out_fifo.sv
`timescale 1ns / 1ps

module scdp_out_fifo
    import scdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output result_t           pop_data,
    output logic [OUT_AW:0]   count
);

    result_t             mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_AW:0]     count_reg,  count_next;
    logic                pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_AW'(OUT_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + OUT_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_AW'(OUT_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + OUT_AW'(1);
        end
        count_next = count_reg + {{OUT_AW{1'b0}}, push} - {{OUT_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
